@@ src/nbsbm_pkg.sv @@
// Shared types, widths and saturation helper for the B-spline blending matrix block.
package nbsbm_pkg;

    localparam int KW       = 63;   // knot time width
    localparam int NK       = 6;    // knots per request
    localparam int NR       = 4;    // matrix rows
    localparam int NC       = 4;    // coefficients per row
    localparam int QB       = 31;   // quotient bits below the saturation point
    localparam int DIV_LAT  = QB + 2;
    localparam int LVL_LAT  = 3;
    localparam int IN_W     = ((NK * KW + 7) / 8) * 8;
    localparam int OUT_BITS = 2 + 2 * NC * 32;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef logic signed [31:0] coef_t;
    typedef logic [1:0] row_t;

    localparam row_t  LAST_ROW = 2'd3;
    localparam coef_t SAT_POS  = 32'sh7FFFFFFF;
    localparam coef_t SAT_NEG  = 32'sh80000001;
    localparam logic signed [71:0] LIM72 = 72'sd2147483647;

    // Clamp a wide signed value to the symmetric 32-bit range.
    function automatic coef_t sat32(input logic signed [71:0] v);
        coef_t r;
        if (v > LIM72) begin
            r = SAT_POS;
        end else if (v < -LIM72) begin
            r = SAT_NEG;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ src/nbsbm_div.sv @@
// Pipelined restoring divider lane producing one saturated signed knot ratio.
module nbsbm_div #(
    parameter int FRAC_BITS = 24
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [nbsbm_pkg::KW-1:0]  num_mag_i,
    input  logic                      num_neg_i,
    input  logic [nbsbm_pkg::KW-1:0]  den_mag_i,
    input  logic                      den_pos_i,
    output nbsbm_pkg::coef_t          ratio_o
);
    import nbsbm_pkg::*;

    localparam int XW = KW + FRAC_BITS;
    localparam int HW = XW - QB;
    localparam int CW = (HW > KW) ? HW : KW;

    logic [XW-1:0] dividend;
    logic [HW-1:0] head;
    logic [KW:0]   trial [1:QB];

    logic [KW-1:0] rem_reg [QB+1];
    logic [KW-1:0] rem_next [QB+1];
    logic [QB-1:0] low_reg [QB+1];
    logic [QB-1:0] low_next [QB+1];
    logic [QB-1:0] q_reg [QB+1];
    logic [QB-1:0] q_next [QB+1];
    logic [KW-1:0] den_reg [QB+1];
    logic [KW-1:0] den_next [QB+1];
    logic          sat_reg [QB+1];
    logic          sat_next [QB+1];
    logic          neg_reg [QB+1];
    logic          neg_next [QB+1];
    logic          pos_reg [QB+1];
    logic          pos_next [QB+1];
    coef_t         mag;
    coef_t         ratio_reg;
    coef_t         ratio_next;

    always_comb begin
        dividend    = {num_mag_i, {FRAC_BITS{1'b0}}};
        head        = dividend[XW-1:QB];
        // A quotient of 2^31 or more saturates, so only 31 bits are developed.
        sat_next[0] = CW'(head) >= CW'(den_mag_i);
        rem_next[0] = KW'(head);
        low_next[0] = dividend[QB-1:0];
        q_next[0]   = '0;
        den_next[0] = den_mag_i;
        neg_next[0] = num_neg_i;
        pos_next[0] = den_pos_i;
        for (int j = 1; j <= QB; j++) begin
            trial[j] = {rem_reg[j-1], low_reg[j-1][QB-1]};
            if (trial[j] >= {1'b0, den_reg[j-1]}) begin
                rem_next[j] = KW'(trial[j] - {1'b0, den_reg[j-1]});
                q_next[j]   = {q_reg[j-1][QB-2:0], 1'b1};
            end else begin
                rem_next[j] = KW'(trial[j]);
                q_next[j]   = {q_reg[j-1][QB-2:0], 1'b0};
            end
            low_next[j] = {low_reg[j-1][QB-2:0], 1'b0};
            den_next[j] = den_reg[j-1];
            sat_next[j] = sat_reg[j-1];
            neg_next[j] = neg_reg[j-1];
            pos_next[j] = pos_reg[j-1];
        end
        mag = sat_reg[QB] ? SAT_POS : coef_t'({1'b0, q_reg[QB]});
        if (!pos_reg[QB]) begin
            ratio_next = '0;
        end else if (neg_reg[QB]) begin
            ratio_next = -mag;
        end else begin
            ratio_next = mag;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j <= QB; j++) begin
                rem_reg[j] <= rem_next[j];
                low_reg[j] <= low_next[j];
                q_reg[j]   <= q_next[j];
                den_reg[j] <= den_next[j];
                sat_reg[j] <= sat_next[j];
                neg_reg[j] <= neg_next[j];
                pos_reg[j] <= pos_next[j];
            end
            ratio_reg <= ratio_next;
        end
    end

    assign ratio_o = ratio_reg;

endmodule

@@ src/nbsbm_level.sv @@
// One Cox-de Boor recurrence level: multiply, round and saturate, then sum terms.
module nbsbm_level #(
    parameter int LVL       = 1,
    parameter int FRAC_BITS = 24
) (
    input  logic             aclk,
    input  logic             en,
    input  nbsbm_pkg::coef_t cur_i [LVL][4],
    input  nbsbm_pkg::coef_t ra1_i [LVL+1],
    input  nbsbm_pkg::coef_t rb1_i [LVL+1],
    input  nbsbm_pkg::coef_t ra2_i [LVL+1],
    input  nbsbm_pkg::coef_t rb2_i [LVL+1],
    output nbsbm_pkg::coef_t row_o [LVL+1][4]
);
    import nbsbm_pkg::*;

    localparam int RO = LVL + 1;

    coef_t src1 [RO][4];
    coef_t src2 [RO][4];

    logic signed [63:0] pa_reg [RO][2][4];
    logic signed [63:0] pa_next [RO][2][4];
    logic signed [63:0] pb_reg [RO][2][4];
    logic signed [63:0] pb_next [RO][2][4];
    logic signed [64:0] vsum [RO][2][4];
    logic signed [64:0] vfl [RO][2][4];
    logic signed [65:0] vrnd [RO][2][4];
    coef_t              term_reg [RO][2][4];
    coef_t              term_next [RO][2][4];
    coef_t              row_reg [RO][4];
    coef_t              row_next [RO][4];

    // The first term of row r comes from row r-1, the second from row r.
    for (genvar r = 0; r < RO; r++) begin : g_src
        for (genvar i = 0; i < 4; i++) begin : g_col
            if (r >= 1) begin : g_t1
                assign src1[r][i] = cur_i[r-1][i];
            end else begin : g_z1
                assign src1[r][i] = '0;
            end
            if (r < LVL) begin : g_t2
                assign src2[r][i] = cur_i[r][i];
            end else begin : g_z2
                assign src2[r][i] = '0;
            end
        end
    end

    always_comb begin
        for (int r = 0; r < RO; r++) begin
            for (int i = 0; i < 4; i++) begin
                pa_next[r][0][i] = 64'(ra1_i[r]) * 64'(src1[r][i]);
                pa_next[r][1][i] = 64'(ra2_i[r]) * 64'(src2[r][i]);
            end
            pb_next[r][0][0] = '0;
            pb_next[r][1][0] = '0;
            for (int i = 1; i < 4; i++) begin
                pb_next[r][0][i] = 64'(rb1_i[r]) * 64'(src1[r][i-1]);
                pb_next[r][1][i] = 64'(rb2_i[r]) * 64'(src2[r][i-1]);
            end
        end
    end

    // Round to nearest with ties toward plus infinity, then saturate each term.
    always_comb begin
        for (int r = 0; r < RO; r++) begin
            for (int t = 0; t < 2; t++) begin
                for (int i = 0; i < 4; i++) begin
                    vsum[r][t][i] = 65'(pa_reg[r][t][i]) + 65'(pb_reg[r][t][i]);
                    vfl[r][t][i]  = vsum[r][t][i] >>> FRAC_BITS;
                    vrnd[r][t][i] = 66'(vfl[r][t][i])
                                    + 66'($signed({1'b0, vsum[r][t][i][FRAC_BITS-1]}));
                    term_next[r][t][i] = sat32(72'(vrnd[r][t][i]));
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r < RO; r++) begin
            for (int i = 0; i < 4; i++) begin
                row_next[r][i] = sat32(72'(term_reg[r][0][i]) + 72'(term_reg[r][1][i]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            term_reg <= term_next;
            row_reg  <= row_next;
        end
    end

    assign row_o = row_reg;

endmodule

@@ src/nonuniform_bspline_basis_matrix.sv @@
// Top level of the non-uniform cubic B-spline blending matrix pipeline.
//
//  Channel  Direction  Beat contents
//  s_       in         tdata: knot_time_0..knot_time_5, 63 bits each, rest zero
//  m_       out        tdata: row_index, basis_c0..c3, cumul_c0..cumul_c3;
//                      tuser: degenerate; tlast: last_row
//
// Each request yields four result rows, one per cycle while m_tready is high, so
// the output row serializer limits how often new requests are taken. The
// datapath itself can take a request every cycle unless stalled: a 44-stage pipeline (knot
// differences, a 33-stage divider per ratio, three recurrence levels of three
// stages each, and a cumulative-sum stage). Reset clears only valid bits and the serializer.
// When the serializer is busy and the last stage is full, the whole pipeline
// holds in place and s_tready drops; nothing is dropped or repeated.
module nonuniform_bspline_basis_matrix #(
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // knot_time_0 [62:0], knot_time_1 [125:63], ... knot_time_5 [377:315], zero pad
    input  logic [nbsbm_pkg::IN_W-1:0]      s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // row_index [1:0], basis_c0..c3 [129:2], cumul_c0..c3 [257:130], zero pad
    output logic [nbsbm_pkg::OUT_W-1:0]     m_tdata,
    // degenerate [0]
    output logic [0:0]                      m_tuser,
    output logic                            m_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready
);
    import nbsbm_pkg::*;

    localparam int TOTAL = 1 + DIV_LAT + 3 * LVL_LAT + 1;
    localparam coef_t ONE = (COEF_FRAC_BITS >= 31) ? SAT_POS
                                                   : coef_t'(32'sd1 <<< COEF_FRAC_BITS);

    typedef struct packed {
        logic          neg;
        logic [KW-1:0] mag;
    } diff_t;

    typedef struct packed {
        logic deg;
        logic pos_h;
        logic pos42;
        logic pos52;
    } side_t;

    typedef struct packed {
        coef_t q21_31;
        coef_t qh31;
        coef_t one42;
        coef_t qh42;
    } lvl2_t;

    typedef struct packed {
        coef_t qh30;
        coef_t q20_30;
        coef_t q42_41;
        coef_t qh41;
        coef_t q21_41;
        coef_t one52;
        coef_t qh52;
    } lvl3_t;

    // Knot difference x - y as sign and magnitude.
    function automatic diff_t kdiff(input logic [KW-1:0] x, input logic [KW-1:0] y);
        diff_t d;
        d.neg = x < y;
        d.mag = d.neg ? (y - x) : (x - y);
        return d;
    endfunction

    logic [KW-1:0] knot [NK];

    logic adv;
    logic ser_free;
    logic load;

    logic vld_reg [TOTAL];

    // First stage: knot differences and divisor checks.
    diff_t dh_reg, d21_reg, d20_reg, d42_reg;
    diff_t d31_c, d30_c, d41_c, d52_c;
    logic [KW-1:0] m31_reg, m30_reg, m41_reg, m52_reg;
    logic pos31_reg, pos30_reg, pos41_reg, pos52_reg;
    side_t side_next;
    side_t side_reg [TOTAL-1];

    coef_t q_h31, q_21_31, q_h42, q_h30, q_20_30, q_42_41, q_h41, q_21_41, q_h52;

    lvl2_t l2_reg [LVL_LAT];
    lvl3_t l3_reg [2 * LVL_LAT];

    coef_t a1;
    coef_t l1_cur [1][4];
    coef_t l1_ra1 [2], l1_rb1 [2], l1_ra2 [2], l1_rb2 [2];
    coef_t l2_ra1 [3], l2_rb1 [3], l2_ra2 [3], l2_rb2 [3];
    coef_t l3_ra1 [4], l3_rb1 [4], l3_ra2 [4], l3_rb2 [4];
    coef_t l1_rows [2][4];
    coef_t l2_rows [3][4];
    coef_t l3_rows [4][4];

    // Cumulative stage and output serializer.
    coef_t cb_reg [NR][NC];
    coef_t cc_reg [NR][NC];
    logic  cdeg_reg;
    coef_t ob_reg [NR][NC];
    coef_t oc_reg [NR][NC];
    logic  odeg_reg;
    logic  busy_reg, busy_next;
    row_t  row_reg, row_next;

    always_comb begin
        for (int k = 0; k < NK; k++) begin
            knot[k] = s_tdata[KW*k +: KW];
        end
    end

    // The pipeline moves as a whole; it holds only when a finished matrix
    // cannot yet be handed to the serializer.
    assign ser_free = !busy_reg || (m_tready && row_reg == LAST_ROW);
    assign adv      = !vld_reg[TOTAL-1] || ser_free;
    assign load     = adv && vld_reg[TOTAL-1];
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < TOTAL; j++) begin
                vld_reg[j] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= s_tvalid;
            for (int j = 1; j < TOTAL; j++) begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end
    end

    // A divisor that is zero or negative zeroes its ratios and flags the matrix.
    always_comb begin
        side_next.pos_h = knot[3] > knot[2];
        side_next.pos42 = knot[4] > knot[2];
        side_next.pos52 = knot[5] > knot[2];
        side_next.deg   = !(knot[3] > knot[2]) || !(knot[3] > knot[1])
                          || !(knot[4] > knot[2]) || !(knot[3] > knot[0])
                          || !(knot[4] > knot[1]) || !(knot[5] > knot[2]);
    end

    // Divisor magnitudes; their sign only matters through the positive checks.
    always_comb begin
        d31_c = kdiff(knot[3], knot[1]);
        d30_c = kdiff(knot[3], knot[0]);
        d41_c = kdiff(knot[4], knot[1]);
        d52_c = kdiff(knot[5], knot[2]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dh_reg      <= kdiff(knot[3], knot[2]);
            d21_reg     <= kdiff(knot[2], knot[1]);
            d20_reg     <= kdiff(knot[2], knot[0]);
            d42_reg     <= kdiff(knot[4], knot[2]);
            m31_reg     <= d31_c.mag;
            m30_reg     <= d30_c.mag;
            m41_reg     <= d41_c.mag;
            m52_reg     <= d52_c.mag;
            pos31_reg   <= knot[3] > knot[1];
            pos30_reg   <= knot[3] > knot[0];
            pos41_reg   <= knot[4] > knot[1];
            pos52_reg   <= knot[5] > knot[2];
            side_reg[0] <= side_next;
            for (int j = 1; j < TOTAL - 1; j++) begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // Nine ratios need a real division; ratios of a difference to itself are
    // the constant one and ratios with a zero numerator are zero.
    nbsbm_div #(.FRAC_BITS(COEF_FRAC_BITS)) u_div_h31 (
        .aclk(aclk), .en(adv), .num_mag_i(dh_reg.mag), .num_neg_i(dh_reg.neg),
        .den_mag_i(m31_reg), .den_pos_i(pos31_reg), .ratio_o(q_h31));
    nbsbm_div #(.FRAC_BITS(COEF_FRAC_BITS)) u_div_21_31 (
        .aclk(aclk), .en(adv), .num_mag_i(d21_reg.mag), .num_neg_i(d21_reg.neg),
        .den_mag_i(m31_reg), .den_pos_i(pos31_reg), .ratio_o(q_21_31));
    nbsbm_div #(.FRAC_BITS(COEF_FRAC_BITS)) u_div_h42 (
        .aclk(aclk), .en(adv), .num_mag_i(dh_reg.mag), .num_neg_i(dh_reg.neg),
        .den_mag_i(d42_reg.mag), .den_pos_i(side_reg[0].pos42), .ratio_o(q_h42));
    nbsbm_div #(.FRAC_BITS(COEF_FRAC_BITS)) u_div_h30 (
        .aclk(aclk), .en(adv), .num_mag_i(dh_reg.mag), .num_neg_i(dh_reg.neg),
        .den_mag_i(m30_reg), .den_pos_i(pos30_reg), .ratio_o(q_h30));
    nbsbm_div #(.FRAC_BITS(COEF_FRAC_BITS)) u_div_20_30 (
        .aclk(aclk), .en(adv), .num_mag_i(d20_reg.mag), .num_neg_i(d20_reg.neg),
        .den_mag_i(m30_reg), .den_pos_i(pos30_reg), .ratio_o(q_20_30));
    nbsbm_div #(.FRAC_BITS(COEF_FRAC_BITS)) u_div_42_41 (
        .aclk(aclk), .en(adv), .num_mag_i(d42_reg.mag), .num_neg_i(d42_reg.neg),
        .den_mag_i(m41_reg), .den_pos_i(pos41_reg), .ratio_o(q_42_41));
    nbsbm_div #(.FRAC_BITS(COEF_FRAC_BITS)) u_div_h41 (
        .aclk(aclk), .en(adv), .num_mag_i(dh_reg.mag), .num_neg_i(dh_reg.neg),
        .den_mag_i(m41_reg), .den_pos_i(pos41_reg), .ratio_o(q_h41));
    nbsbm_div #(.FRAC_BITS(COEF_FRAC_BITS)) u_div_21_41 (
        .aclk(aclk), .en(adv), .num_mag_i(d21_reg.mag), .num_neg_i(d21_reg.neg),
        .den_mag_i(m41_reg), .den_pos_i(pos41_reg), .ratio_o(q_21_41));
    nbsbm_div #(.FRAC_BITS(COEF_FRAC_BITS)) u_div_h52 (
        .aclk(aclk), .en(adv), .num_mag_i(dh_reg.mag), .num_neg_i(dh_reg.neg),
        .den_mag_i(m52_reg), .den_pos_i(pos52_reg), .ratio_o(q_h52));

    // Ratios for the later levels wait until those levels start.
    always_ff @(posedge aclk) begin
        if (adv) begin
            l2_reg[0].q21_31 <= q_21_31;
            l2_reg[0].qh31   <= q_h31;
            l2_reg[0].one42  <= side_reg[DIV_LAT].pos42 ? ONE : '0;
            l2_reg[0].qh42   <= q_h42;
            for (int j = 1; j < LVL_LAT; j++) begin
                l2_reg[j] <= l2_reg[j-1];
            end
            l3_reg[0].qh30   <= q_h30;
            l3_reg[0].q20_30 <= q_20_30;
            l3_reg[0].q42_41 <= q_42_41;
            l3_reg[0].qh41   <= q_h41;
            l3_reg[0].q21_41 <= q_21_41;
            l3_reg[0].one52  <= side_reg[DIV_LAT].pos52 ? ONE : '0;
            l3_reg[0].qh52   <= q_h52;
            for (int j = 1; j < 2 * LVL_LAT; j++) begin
                l3_reg[j] <= l3_reg[j-1];
            end
        end
    end

    // Level one starts from the constant basis one.
    always_comb begin
        a1 = side_reg[DIV_LAT].pos_h ? ONE : '0;
        l1_cur[0][0] = ONE;
        l1_cur[0][1] = '0;
        l1_cur[0][2] = '0;
        l1_cur[0][3] = '0;
        l1_ra1[0] = '0;  l1_rb1[0] = '0;  l1_ra2[0] = a1;  l1_rb2[0] = -a1;
        l1_ra1[1] = '0;  l1_rb1[1] = a1;  l1_ra2[1] = '0;  l1_rb2[1] = '0;
    end

    always_comb begin
        l2_ra1[0] = '0;
        l2_rb1[0] = '0;
        l2_ra2[0] = l2_reg[LVL_LAT-1].qh31;
        l2_rb2[0] = -l2_reg[LVL_LAT-1].qh31;
        l2_ra1[1] = l2_reg[LVL_LAT-1].q21_31;
        l2_rb1[1] = l2_reg[LVL_LAT-1].qh31;
        l2_ra2[1] = l2_reg[LVL_LAT-1].one42;
        l2_rb2[1] = -l2_reg[LVL_LAT-1].qh42;
        l2_ra1[2] = '0;
        l2_rb1[2] = l2_reg[LVL_LAT-1].qh42;
        l2_ra2[2] = '0;
        l2_rb2[2] = '0;
    end

    always_comb begin
        l3_ra1[0] = '0;
        l3_rb1[0] = '0;
        l3_ra2[0] = l3_reg[2*LVL_LAT-1].qh30;
        l3_rb2[0] = -l3_reg[2*LVL_LAT-1].qh30;
        l3_ra1[1] = l3_reg[2*LVL_LAT-1].q20_30;
        l3_rb1[1] = l3_reg[2*LVL_LAT-1].qh30;
        l3_ra2[1] = l3_reg[2*LVL_LAT-1].q42_41;
        l3_rb2[1] = -l3_reg[2*LVL_LAT-1].qh41;
        l3_ra1[2] = l3_reg[2*LVL_LAT-1].q21_41;
        l3_rb1[2] = l3_reg[2*LVL_LAT-1].qh41;
        l3_ra2[2] = l3_reg[2*LVL_LAT-1].one52;
        l3_rb2[2] = -l3_reg[2*LVL_LAT-1].qh52;
        l3_ra1[3] = '0;
        l3_rb1[3] = l3_reg[2*LVL_LAT-1].qh52;
        l3_ra2[3] = '0;
        l3_rb2[3] = '0;
    end

    nbsbm_level #(.LVL(1), .FRAC_BITS(COEF_FRAC_BITS)) u_lvl1 (
        .aclk(aclk), .en(adv), .cur_i(l1_cur),
        .ra1_i(l1_ra1), .rb1_i(l1_rb1), .ra2_i(l1_ra2), .rb2_i(l1_rb2),
        .row_o(l1_rows));

    nbsbm_level #(.LVL(2), .FRAC_BITS(COEF_FRAC_BITS)) u_lvl2 (
        .aclk(aclk), .en(adv), .cur_i(l1_rows),
        .ra1_i(l2_ra1), .rb1_i(l2_rb1), .ra2_i(l2_ra2), .rb2_i(l2_rb2),
        .row_o(l2_rows));

    nbsbm_level #(.LVL(3), .FRAC_BITS(COEF_FRAC_BITS)) u_lvl3 (
        .aclk(aclk), .en(adv), .cur_i(l2_rows),
        .ra1_i(l3_ra1), .rb1_i(l3_rb1), .ra2_i(l3_ra2), .rb2_i(l3_rb2),
        .row_o(l3_rows));

    // Cumulative rows: exact sums of rows r through 3, saturated once.
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NC; i++) begin
                cb_reg[0][i] <= l3_rows[0][i];
                cb_reg[1][i] <= l3_rows[1][i];
                cb_reg[2][i] <= l3_rows[2][i];
                cb_reg[3][i] <= l3_rows[3][i];
                cc_reg[3][i] <= l3_rows[3][i];
                cc_reg[2][i] <= sat32(72'(l3_rows[2][i]) + 72'(l3_rows[3][i]));
                cc_reg[1][i] <= sat32(72'(l3_rows[1][i]) + 72'(l3_rows[2][i])
                                      + 72'(l3_rows[3][i]));
                cc_reg[0][i] <= sat32(72'(l3_rows[0][i]) + 72'(l3_rows[1][i])
                                      + 72'(l3_rows[2][i]) + 72'(l3_rows[3][i]));
            end
            cdeg_reg <= side_reg[TOTAL-2].deg;
        end
    end

    // The serializer holds one matrix and sends a row per accepted beat; the
    // next matrix loads in the same cycle the last row is taken.
    always_comb begin
        busy_next = busy_reg;
        row_next  = row_reg;
        if (load) begin
            busy_next = 1'b1;
            row_next  = '0;
        end else if (busy_reg && m_tready) begin
            if (row_reg == LAST_ROW) begin
                busy_next = 1'b0;
            end else begin
                row_next = row_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            row_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            row_reg  <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ob_reg   <= cb_reg;
            oc_reg   <= cc_reg;
            odeg_reg <= cdeg_reg;
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = (row_reg == LAST_ROW);
    assign m_tuser  = odeg_reg;
    assign m_tdata  = {(OUT_W - OUT_BITS)'(0),
                       oc_reg[row_reg][3], oc_reg[row_reg][2],
                       oc_reg[row_reg][1], oc_reg[row_reg][0],
                       ob_reg[row_reg][3], ob_reg[row_reg][2],
                       ob_reg[row_reg][1], ob_reg[row_reg][0],
                       row_reg};

    // A finished matrix that cannot be handed over stays in the last stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[TOTAL-1] && !adv) |=> vld_reg[TOTAL-1])
        else $error("finished matrix lost while stalled");

    // A matrix is loaded only into an empty serializer or over its last row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (!busy_reg || (m_tvalid && m_tready && m_tlast)))
        else $error("serializer overwritten before its last row was taken");

    // After the last row goes with nothing behind it, the output goes idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast && !load) |=> !m_tvalid)
        else $error("rows repeated after the last row");

    // An empty last stage never blocks new requests.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[TOTAL-1] |-> s_tready)
        else $error("input stalled with an empty pipeline tail");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the non-uniform cubic B-spline blending matrix block.
`timescale 1ns / 1ps

module tb_top;
    import nbsbm_pkg::*;

    localparam int FRAC = 24;
    localparam longint SAT = 64'sd2147483647;
    localparam int LIMIT_CYCLES = 300000;
    localparam logic [62:0] KMAX = {63{1'b1}};

    typedef logic [62:0] knot_t;
    typedef knot_t knot_set_t [NK];

    typedef struct {
        row_t row;
        coef_t basis [NC];
        coef_t cumul [NC];
        logic degen;
        logic last;
    } blend_row_t;

    typedef struct {
        logic neg;
        logic [63:0] mag;
    } sdiff_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic [IN_W-1:0] s_tdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [OUT_W-1:0] m_tdata;
    logic [0:0] m_tuser;
    logic m_tlast;
    logic m_tvalid;
    logic m_tready = 1'b0;

    knot_set_t knot_requests_q [$];
    knot_set_t knots_on_bus;
    blend_row_t blend_rows_q [$];
    int mismatches = 0;
    int accepted = 0;
    int cycles = 0;
    int total_requests = 0;
    bit hold_off = 1'b0;

    nonuniform_bspline_basis_matrix #(.COEF_FRAC_BITS(FRAC)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor: Cox-de Boor recurrence in fixed point, row by row.
    // ---------------------------------------------------------------
    function automatic longint clamp_sym(input longint v);
        if (v > SAT) return SAT;
        if (v < -SAT) return -SAT;
        return v;
    endfunction

    function automatic sdiff_t knot_diff(input knot_t x, input knot_t y);
        sdiff_t d;
        d.neg = (x < y);
        d.mag = d.neg ? {1'b0, y} - {1'b0, x} : {1'b0, x} - {1'b0, y};
        return d;
    endfunction

    // Truncating restoring division with early saturation; a non-positive
    // divisor gives zero and flags the request as degenerate.
    function automatic longint knot_ratio(input sdiff_t num, input sdiff_t den,
                                          inout logic degen);
        logic [63:0] q;
        logic [63:0] r;
        if (den.neg || den.mag == 0) begin
            degen = 1'b1;
            return 0;
        end
        q = num.mag / den.mag;
        r = num.mag % den.mag;
        if (q > 64'(SAT)) begin
            q = 64'(SAT);
        end else begin
            for (int i = 0; i < FRAC; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= den.mag) begin
                    r = r - den.mag;
                    q[0] = 1'b1;
                end
                if (q > 64'(SAT)) begin
                    q = 64'(SAT);
                    break;
                end
            end
        end
        return num.neg ? -longint'(q) : longint'(q);
    endfunction

    // Round to nearest with ties toward +inf: floor shift plus the half bit.
    function automatic longint round_frac(input longint v);
        return (v >>> FRAC) + longint'(v[FRAC-1]);
    endfunction

    task automatic predict_blend(input knot_set_t t);
        longint cur [NR][NC];
        longint nxt [NR][NC];
        longint acc [NC];
        longint ra, rb, s;
        sdiff_t h, nh, den;
        logic degen;
        int l;
        blend_row_t row;
        degen = 1'b0;
        h = knot_diff(t[3], t[2]);
        nh = h;
        nh.neg = ~h.neg;
        foreach (cur[a, b]) cur[a][b] = 0;
        cur[0][0] = clamp_sym(longint'(1) << FRAC);
        for (int k = 1; k <= 3; k++) begin
            foreach (nxt[a, b]) nxt[a][b] = 0;
            for (int r = 0; r <= k; r++) begin
                l = 2 - k + r;
                foreach (acc[i]) acc[i] = 0;
                // Rising term from the basis one row up.
                if (r >= 1) begin
                    den = knot_diff(t[l + k], t[l]);
                    ra = knot_ratio(knot_diff(t[2], t[l]), den, degen);
                    rb = knot_ratio(h, den, degen);
                    for (int i = 0; i < NC; i++)
                        acc[i] += clamp_sym(round_frac(ra * cur[r-1][i] +
                                  (i > 0 ? rb * cur[r-1][i-1] : 0)));
                end
                // Falling term from the basis on this row.
                if (r <= k - 1) begin
                    den = knot_diff(t[l + k + 1], t[l + 1]);
                    ra = knot_ratio(knot_diff(t[l + k + 1], t[2]), den, degen);
                    rb = knot_ratio(nh, den, degen);
                    for (int i = 0; i < NC; i++)
                        acc[i] += clamp_sym(round_frac(ra * cur[r][i] +
                                  (i > 0 ? rb * cur[r][i-1] : 0)));
                end
                for (int i = 0; i < NC; i++) nxt[r][i] = clamp_sym(acc[i]);
            end
            cur = nxt;
        end
        for (int r = 0; r < NR; r++) begin
            row.row = row_t'(r);
            for (int i = 0; i < NC; i++) begin
                s = 0;
                for (int q = r; q < NR; q++) s += cur[q][i];
                row.basis[i] = coef_t'(cur[r][i]);
                row.cumul[i] = coef_t'(clamp_sym(s));
            end
            row.degen = degen;
            row.last = (r == NR - 1);
            blend_rows_q.insert(blend_rows_q.size(), row);
        end
    endtask

    // ---------------------------------------------------------------
    // Idle pattern: sender 29% / receiver 80% first, then swapped, then none.
    // ---------------------------------------------------------------
    function automatic int phase_of(input int n);
        return (n < total_requests / 3) ? 0 : (n < 2 * total_requests / 3) ? 1 : 2;
    endfunction

    // Driver: a new request is loaded only when the bus is free or just taken.
    always @(posedge aclk) begin
        logic [IN_W-1:0] word;
        word = '0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_blend(knots_on_bus);
                accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (knot_requests_q.size() > 0 &&
                    $urandom_range(99) >= (phase_of(accepted) == 0 ? 29 :
                                           phase_of(accepted) == 1 ? 80 : 0)) begin
                    knots_on_bus = knot_requests_q[0];
                    knot_requests_q.delete(0);
                    for (int i = 0; i < NK; i++) word[i*KW +: KW] = knots_on_bus[i];
                    s_tdata <= word;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready pattern, with the long hold-off overriding it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !hold_off &&
                        ($urandom_range(99) >= (phase_of(accepted) == 0 ? 80 :
                                                phase_of(accepted) == 1 ? 29 : 0));
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, want %0d", what, got, want);
        mismatches++;
    endtask

    // Monitor: every accepted row is checked against the oldest prediction.
    always @(posedge aclk) begin
        blend_row_t want;
        coef_t got;
        if (aresetn && m_tvalid && m_tready) begin
            if (blend_rows_q.size() == 0) begin
                report_mismatch("unexpected row", m_tdata[1:0], -1);
            end else begin
                want = blend_rows_q[0];
                blend_rows_q.delete(0);
                if (m_tdata[1:0] !== want.row) report_mismatch("row_index", m_tdata[1:0], want.row);
                for (int i = 0; i < NC; i++) begin
                    got = m_tdata[2 + 32*i +: 32];
                    if (got !== want.basis[i])
                        report_mismatch($sformatf("basis_c%0d", i), got, want.basis[i]);
                    got = m_tdata[130 + 32*i +: 32];
                    if (got !== want.cumul[i])
                        report_mismatch($sformatf("cumul_c%0d", i), got, want.cumul[i]);
                end
                if (m_tuser[0] !== want.degen) report_mismatch("degenerate", m_tuser[0], want.degen);
                if (m_tlast !== want.last) report_mismatch("last_row", m_tlast, want.last);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("nonuniform_bspline_basis_matrix test failed");
            $finish;
        end
    end

    // Long receiver stall in the idle-free phase so the pipeline backs up into s_tready.
    initial begin
        wait (total_requests > 0 && accepted > 2 * total_requests / 3 + 5);
        @(posedge aclk);
        hold_off = 1'b1;
        repeat (400) @(posedge aclk);
        hold_off = 1'b0;
    end

    function automatic knot_t rand_knot();
        return knot_t'({$urandom, $urandom}) & KMAX;
    endfunction

    function automatic void add_request(input knot_set_t t);
        knot_requests_q.insert(knot_requests_q.size(), t);
    endfunction

    // Sorted knot set with gaps of a random scale; a zero gap is allowed.
    function automatic knot_set_t sorted_knots();
        knot_set_t t;
        int scale;
        scale = $urandom_range(3);
        t[0] = rand_knot() >> 2;
        for (int i = 1; i < NK; i++) begin
            case (scale)
                0: t[i] = t[i-1] + $urandom_range(0, 60);
                1: t[i] = t[i-1] + $urandom_range(1, 1_000_000_000);
                2: t[i] = t[i-1] + $urandom;
                default: t[i] = t[i-1] + (rand_knot() >> 6);
            endcase
        end
        return t;
    endfunction

    initial begin
        knot_set_t t;
        // Directed: uniform spacing, real-time spacing, extremes, repeated and
        // unsorted knots, a negative interval, and huge ratios.
        add_request('{0, 1, 2, 3, 4, 5});
        add_request('{0, 1_000_000, 2_000_000, 3_000_000, 4_000_000, 5_000_000});
        add_request('{0, 0, 0, 0, 0, 0});
        add_request('{KMAX, KMAX, KMAX, KMAX, KMAX, KMAX});
        add_request('{0, 0, 0, KMAX, KMAX, KMAX});
        add_request('{0, 1, 2, KMAX - 2, KMAX - 1, KMAX});
        add_request('{10, 20, 20, 30, 40, 50});
        add_request('{10, 20, 30, 30, 40, 50});
        add_request('{10, 10, 30, 40, 40, 50});
        add_request('{50, 40, 30, 20, 10, 0});
        add_request('{0, 10, 30, 20, 40, 50});
        add_request('{0, 1, 2, 1002, 2000, 3000});
        add_request('{0, KMAX - 10, KMAX - 9, KMAX - 8, KMAX - 7, KMAX});
        add_request('{5, 7, 8, 20, 21, 90});
        // Random: mostly sorted sets, the rest raw noise or sets with one knot overwritten.
        repeat (146) begin
            t = sorted_knots();
            case ($urandom_range(9))
                0, 1: foreach (t[i]) t[i] = rand_knot();
                2: begin
                    int a;
                    int b;
                    a = $urandom_range(NK - 1);
                    b = $urandom_range(NK - 1);
                    t[a] = t[b] ^ ($urandom_range(1) ? 63'd0 : rand_knot());
                end
                default: ;
            endcase
            add_request(t);
        end
        total_requests = knot_requests_q.size();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        wait (knot_requests_q.size() == 0 && accepted == total_requests);
        wait (blend_rows_q.size() == 0);
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && blend_rows_q.size() == 0) begin
            $display("nonuniform_bspline_basis_matrix test passed");
        end else begin
            $display("nonuniform_bspline_basis_matrix test failed");
        end
        $finish;
    end

endmodule

@@ nonuniform_bspline_basis_matrix.f @@
src/nbsbm_pkg.sv
src/nbsbm_div.sv
src/nbsbm_level.sv
src/nonuniform_bspline_basis_matrix.sv
tb/tb_top.sv
